>>> hw/rtl/appp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// appp_pkg
// Shared types, constants, the CORDIC arctangent table and 24-bit saturation.
// ----------------------------------------------------------------------------
package appp_pkg;

  localparam int unsigned PosW = 24;
  localparam int unsigned OffW = 20;
  localparam int unsigned WideW = 48;
  localparam int unsigned TableLen = 24;

  localparam logic [0:0] RegLayout = 1'b0;
  localparam logic [0:0] RegTime = 1'b1;

  localparam logic signed [31:0] GainQ30 = 32'sd652032874;

  typedef struct packed {
    logic signed [WideW-1:0] cx;
    logic signed [WideW-1:0] cy;
    logic signed [WideW-1:0] cz;
    logic [31:0]             yaw32;
    logic [31:0]             bearing;
    logic signed [OffW+1:0]  r_base;
    logic signed [OffW+1:0]  r_alt;
    logic signed [OffW-1:0]  h_a;
    logic signed [OffW-1:0]  h_b;
    logic                    outpost;
  } target_t;

  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  function automatic logic signed [PosW-1:0] sat24(input logic signed [WideW+1:0] v);
    logic signed [PosW-1:0] r;
    if (v > $signed({{(WideW+2-PosW){1'b0}}, {1'b0, {(PosW-1){1'b1}}}})) begin
      r = {1'b0, {(PosW-1){1'b1}}};
    end else if (v < $signed({{(WideW+2-PosW){1'b1}}, {1'b1, {(PosW-1){1'b0}}}})) begin
      r = {1'b1, {(PosW-1){1'b0}}};
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/appp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// appp_front
// Predicts center and yaw, then runs a pipelined vectoring CORDIC for bearing.
// ----------------------------------------------------------------------------
module appp_front #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic                          outpost_i,
  input  logic [15:0]                   dt_i,
  input  logic signed [23:0]            center_x_i,
  input  logic signed [23:0]            center_y_i,
  input  logic signed [23:0]            center_z_i,
  input  logic signed [23:0]            vel_x_i,
  input  logic signed [23:0]            vel_y_i,
  input  logic signed [23:0]            vel_z_i,
  input  logic signed [15:0]            heading_i,
  input  logic signed [20:0]            heading_rate_i,
  input  logic [19:0]                   plate_radius_i,
  input  logic signed [19:0]            radius_delta_i,
  input  logic signed [19:0]            height_delta_a_i,
  input  logic signed [19:0]            height_delta_b_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output appp_pkg::target_t             target_o
);
  import appp_pkg::*;

  localparam int unsigned NS = CORDIC_STEPS + 2;
  localparam int unsigned VW = WideW + 24;

  logic                 v_q [NS];
  target_t              t_q [NS];
  logic [31:0]          b_q [NS];
  logic signed [VW-1:0] x_q [NS];
  logic signed [VW-1:0] y_q [NS];
  logic                 adv;

  assign adv = !v_q[NS-1] || ready_i;
  assign ready_o = adv;
  assign valid_o = v_q[NS-1];

  always_comb begin
    target_o = t_q[NS-1];
    target_o.bearing = b_q[NS-1];
  end

  function automatic logic signed [WideW-1:0] mv(input logic signed [23:0] c,
                                                input logic signed [23:0] v,
                                                input logic [15:0] dt);
    logic signed [41:0] p;
    p = v * $signed({1'b0, dt}) + 42'sd32768;
    return WideW'(c) + WideW'(p >>> 16);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < NS; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q[0].cx <= mv(center_x_i, vel_x_i, dt_i);
      t_q[0].cy <= mv(center_y_i, vel_y_i, dt_i);
      t_q[0].cz <= mv(center_z_i, vel_z_i, dt_i);
      t_q[0].yaw32 <= {heading_i, 16'h0} + 32'(heading_rate_i * $signed({1'b0, dt_i}));
      t_q[0].bearing <= '0;
      t_q[0].r_base <= $signed({2'b0, plate_radius_i});
      t_q[0].r_alt <= $signed({2'b0, plate_radius_i}) + 22'(radius_delta_i);
      t_q[0].h_a <= height_delta_a_i;
      t_q[0].h_b <= height_delta_b_i;
      t_q[0].outpost <= outpost_i;
      x_q[0] <= '0;
      y_q[0] <= '0;
      // fold to right half plane, scale by 2^20
      t_q[1] <= t_q[0];
      if (t_q[0].cx < 0) begin
        x_q[1] <= -(VW'(t_q[0].cx) <<< 20);
        y_q[1] <= -(VW'(t_q[0].cy) <<< 20);
        b_q[1] <= 32'h80000000;
      end else begin
        x_q[1] <= VW'(t_q[0].cx) <<< 20;
        y_q[1] <= VW'(t_q[0].cy) <<< 20;
        b_q[1] <= '0;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        t_q[i+2] <= t_q[i+1];
        if (t_q[i+1].cx == 0 && t_q[i+1].cy == 0) begin
          x_q[i+2] <= x_q[i+1];
          y_q[i+2] <= y_q[i+1];
          b_q[i+2] <= '0;
        end else if (y_q[i+1] >= 0) begin
          x_q[i+2] <= x_q[i+1] + (y_q[i+1] >>> i);
          y_q[i+2] <= y_q[i+1] - (x_q[i+1] >>> i);
          b_q[i+2] <= b_q[i+1] + atan_turn(i);
        end else begin
          x_q[i+2] <= x_q[i+1] - (y_q[i+1] >>> i);
          y_q[i+2] <= y_q[i+1] + (x_q[i+1] >>> i);
          b_q[i+2] <= b_q[i+1] - atan_turn(i);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NS-1] |-> ready_o) else $error("front stalls while empty");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o) else $error("front dropped target");
  a_orig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && target_o.cx == 0 && target_o.cy == 0 |-> target_o.bearing == 0)
    else $error("bearing at origin");
`endif
endmodule

>>> hw/rtl/appp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// appp_fifo
// Two-entry queue of predicted targets between front and back.
// ----------------------------------------------------------------------------
module appp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  appp_pkg::target_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output appp_pkg::target_t data_o
);
  import appp_pkg::*;

  target_t    mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o = mem_q[rp_q];
  assign push = valid_i && ready_o;
  assign pop = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wp_q != rp_q)) else $error("queue pointers");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (wp_q == rp_q)) else $error("queue full pointers");
`endif
endmodule

>>> hw/rtl/appp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// appp_back
// Issues one plate per cycle, unless stalled, via a pipelined sin/cos CORDIC.
// ----------------------------------------------------------------------------
module appp_back #(
  parameter int unsigned ANGLE_BITS   = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  appp_pkg::target_t        target_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [1:0]               plate_index_o,
  output logic signed [23:0]       plate_x_o,
  output logic signed [23:0]       plate_y_o,
  output logic signed [23:0]       plate_z_o,
  output logic signed [15:0]       plate_yaw_o,
  output logic signed [15:0]       bearing_offset_o,
  output logic                     last_plate_o
);
  import appp_pkg::*;

  localparam int unsigned AB = ANGLE_BITS;
  localparam logic [AB-1:0] StepQ = AB'(1 << (AB - 2));
  localparam logic [AB-1:0] StepT = AB'(((64'd1 << AB) * 2 + 3) / 6);
  localparam logic [31:0] YawRnd = 32'(1) << (31 - AB);
  localparam int unsigned NS = CORDIC_STEPS + 4;

  typedef struct packed {
    logic [1:0]              idx;
    logic                    last;
    logic                    flip;
    logic [31:0]             p32;
    logic [31:0]             bearing;
    logic signed [WideW-1:0] cx;
    logic signed [WideW-1:0] cy;
    logic signed [WideW-1:0] z;
    logic signed [OffW+1:0]  r;
  } plate_t;

  logic [1:0]         idx_q;
  logic               v_q [NS];
  plate_t             p_q [NS];
  logic signed [33:0] x_q [NS];
  logic signed [33:0] y_q [NS];
  logic signed [33:0] z_q [NS];
  logic signed [WideW+1:0] px_q, py_q;
  logic               adv, is_last;
  logic [AB-1:0]      yaw_ab, pyaw;
  logic [31:0]        a32;
  plate_t             np;

  assign adv = !v_q[NS-1] || ready_i;
  assign is_last = target_i.outpost ? (idx_q == 2'd2) : (idx_q == 2'd3);
  assign ready_o = adv && is_last;
  assign yaw_ab = AB'((target_i.yaw32 + YawRnd) >> (32 - AB));

  always_comb begin
    pyaw = yaw_ab + AB'(idx_q) * (target_i.outpost ? StepT : StepQ);
    np.idx = idx_q;
    np.last = is_last;
    np.p32 = 32'(pyaw) << (32 - AB);
    np.bearing = target_i.bearing;
    np.cx = target_i.cx;
    np.cy = target_i.cy;
    np.r = target_i.r_base;
    np.z = target_i.cz;
    if (!target_i.outpost) begin
      if (idx_q[0]) begin
        np.r = target_i.r_alt;
        np.z = target_i.cz + WideW'(target_i.h_a);
      end
    end else if (idx_q == 2'd0) begin
      np.z = target_i.cz + WideW'(target_i.h_a);
    end else if (idx_q == 2'd2) begin
      np.z = target_i.cz + WideW'(target_i.h_b);
    end
    np.flip = np.p32[31] ^ np.p32[30];
    a32 = np.flip ? np.p32 + 32'h80000000 : np.p32;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      for (int i = 0; i < NS; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      if (valid_i) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      v_q[0] <= valid_i;
      for (int i = 1; i < NS; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= np;
      x_q[0] <= 34'(GainQ30);
      y_q[0] <= '0;
      z_q[0] <= 34'($signed(a32));
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        p_q[i+1] <= p_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - 34'(atan_turn(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + 34'(atan_turn(i));
        end
      end
      p_q[CORDIC_STEPS+1] <= p_q[CORDIC_STEPS];
      x_q[CORDIC_STEPS+1] <= p_q[CORDIC_STEPS].flip ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
      y_q[CORDIC_STEPS+1] <= p_q[CORDIC_STEPS].flip ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];
      // multiply stage
      p_q[CORDIC_STEPS+2] <= p_q[CORDIC_STEPS+1];
      x_q[CORDIC_STEPS+2] <= 34'((p_q[CORDIC_STEPS+1].r * x_q[CORDIC_STEPS+1]
                                   + 56'sd536870912) >>> 30);
      y_q[CORDIC_STEPS+2] <= 34'((p_q[CORDIC_STEPS+1].r * y_q[CORDIC_STEPS+1]
                                   + 56'sd536870912) >>> 30);
      p_q[CORDIC_STEPS+3] <= p_q[CORDIC_STEPS+2];
      px_q <= (WideW+2)'(p_q[CORDIC_STEPS+2].cx) - (WideW+2)'(x_q[CORDIC_STEPS+2]);
      py_q <= (WideW+2)'(p_q[CORDIC_STEPS+2].cy) - (WideW+2)'(y_q[CORDIC_STEPS+2]);
    end
  end

  assign valid_o = v_q[NS-1];
  assign plate_index_o = p_q[NS-1].idx;
  assign last_plate_o = p_q[NS-1].last;
  assign plate_x_o = sat24(px_q);
  assign plate_y_o = sat24(py_q);
  assign plate_z_o = sat24((WideW+2)'(p_q[NS-1].z));
  assign plate_yaw_o = 16'((p_q[NS-1].p32 + 32'h8000) >> 16);
  assign bearing_offset_o = 16'((p_q[NS-1].p32 - p_q[NS-1].bearing + 32'h8000) >> 16);

`ifndef SYNTHESIS
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o |-> is_last) else $error("target popped early");
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_plate_o |-> plate_index_o >= 2'd2) else $error("bad last plate");
  a_idx0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && adv && is_last |=> idx_q == 2'd0) else $error("index not restarted");
`endif
endmodule

>>> hw/rtl/armor_plate_position_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// armor_plate_position_predictor
// Predicts a rotating target ahead and emits the position of each plate.
// ----------------------------------------------------------------------------
// One target request yields four plate results (robot layout) or three
// (outpost layout), one per cycle while the output is not stalled. A
// two-entry queue decouples the bearing pipeline from the sin/cos pipeline.
// Write registers only while idle.
module armor_plate_position_predictor #(
  parameter int unsigned ANGLE_BITS   = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [23:0] center_x_i,
  input  logic signed [23:0] center_y_i,
  input  logic signed [23:0] center_z_i,
  input  logic signed [23:0] vel_x_i,
  input  logic signed [23:0] vel_y_i,
  input  logic signed [23:0] vel_z_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [20:0] heading_rate_i,
  input  logic [19:0]        plate_radius_i,
  input  logic signed [19:0] radius_delta_i,
  input  logic signed [19:0] height_delta_a_i,
  input  logic signed [19:0] height_delta_b_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [1:0]         plate_index_o,
  output logic signed [23:0] plate_x_o,
  output logic signed [23:0] plate_y_o,
  output logic signed [23:0] plate_z_o,
  output logic signed [15:0] plate_yaw_o,
  output logic signed [15:0] bearing_offset_o,
  output logic               last_plate_o
);
  import appp_pkg::*;

  logic        outpost_q;
  logic [15:0] dt_q;
  logic        fv, fr, qv, qr;
  target_t     ft, qt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outpost_q <= 1'b0;
      dt_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegLayout) outpost_q <= cfg_data_i[0];
      if (cfg_idx_i == RegTime) dt_q <= cfg_data_i;
    end
  end

  appp_front #(.CORDIC_STEPS(CORDIC_STEPS)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .outpost_i(outpost_q), .dt_i(dt_q),
    .center_x_i, .center_y_i, .center_z_i, .vel_x_i, .vel_y_i, .vel_z_i,
    .heading_i, .heading_rate_i, .plate_radius_i, .radius_delta_i,
    .height_delta_a_i, .height_delta_b_i,
    .valid_o(fv), .ready_i(fr), .target_o(ft)
  );

  appp_fifo u_fifo (
    .clk_i, .rst_ni, .valid_i(fv), .ready_o(fr), .data_i(ft),
    .valid_o(qv), .ready_i(qr), .data_o(qt)
  );

  appp_back #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .valid_i(qv), .ready_o(qr), .target_i(qt),
    .valid_o, .ready_i, .plate_index_o, .plate_x_o, .plate_y_o, .plate_z_o,
    .plate_yaw_o, .bearing_offset_o, .last_plate_o
  );
endmodule

>>> tb/plate_prediction_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plate_prediction_checker
// Watches the config port and both request channels, computes the expected
// plate results of every accepted target and compares them in order.
// ----------------------------------------------------------------------------
module plate_prediction_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               valid_i,
  input  logic               ready_o,
  input  logic signed [23:0] center_x_i,
  input  logic signed [23:0] center_y_i,
  input  logic signed [23:0] center_z_i,
  input  logic signed [23:0] vel_x_i,
  input  logic signed [23:0] vel_y_i,
  input  logic signed [23:0] vel_z_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [20:0] heading_rate_i,
  input  logic [19:0]        plate_radius_i,
  input  logic signed [19:0] radius_delta_i,
  input  logic signed [19:0] height_delta_a_i,
  input  logic signed [19:0] height_delta_b_i,
  input  logic               valid_o,
  input  logic               ready_i,
  input  logic [1:0]         plate_index_o,
  input  logic signed [23:0] plate_x_o,
  input  logic signed [23:0] plate_y_o,
  input  logic signed [23:0] plate_z_o,
  input  logic signed [15:0] plate_yaw_o,
  input  logic signed [15:0] bearing_offset_o,
  input  logic               last_plate_o,
  output int                 fail_count_o,
  output int                 plates_pending_o
);
  import appp_pkg::*;

  localparam int unsigned Steps = 16;

  typedef struct packed {
    logic [1:0]  idx;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic [15:0] yaw;
    logic [15:0] err;
    logic        last;
  } plate_t;

  plate_t      plate_q[$];
  logic        outpost_mode;
  logic [15:0] lead_time;

  assign plates_pending_o = plate_q.size();

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [23:0] clamp24(input longint v);
    if (v > 64'sd8388607) return 24'h7FFFFF;
    if (v < -64'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic void plate_trig(input logic [31:0] a, output longint c,
                                     output longint s);
    logic [31:0] ang;
    bit          flip;
    longint      x, y, z, xs, ys;
    ang = a;
    flip = 0;
    if (a[31:30] == 2'd1 || a[31:30] == 2'd2) begin
      ang = a + 32'h80000000;
      flip = 1;
    end
    x = longint'(GainQ30);
    y = 0;
    z = longint'($signed(ang));
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_turn(i));
      end else begin
        x += ys; y -= xs; z += longint'(atan_turn(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] center_bearing(input longint cx, input longint cy);
    longint      x, y, xs, ys;
    logic [31:0] z;
    if (cx == 0 && cy == 0) return 32'h0;
    x = cx <<< 20;
    y = cy <<< 20;
    z = 32'h0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_turn(i);
      end else begin
        x -= ys; y += xs; z -= atan_turn(i);
      end
    end
    return z;
  endfunction

  task automatic predict_plates();
    longint      dt, cx, cy, cz, base_r, r, pz, c, s, turn;
    logic [31:0] yaw32, bearing, p32, diff;
    logic [15:0] yaw_ab, pyaw, step;
    int          count;
    plate_t      p;
    dt = longint'(lead_time);
    cx = longint'(center_x_i) + rnd_shift(longint'(vel_x_i) * dt, 16);
    cy = longint'(center_y_i) + rnd_shift(longint'(vel_y_i) * dt, 16);
    cz = longint'(center_z_i) + rnd_shift(longint'(vel_z_i) * dt, 16);
    turn = longint'(heading_rate_i) * dt;
    yaw32 = {heading_i, 16'h0} + turn[31:0];
    p32 = yaw32 + 32'h8000;
    yaw_ab = p32[31:16];
    bearing = center_bearing(cx, cy);
    count = outpost_mode ? 3 : 4;
    step = outpost_mode ? 16'd21845 : 16'd16384;
    base_r = longint'(plate_radius_i);
    for (int i = 0; i < count; i++) begin
      pyaw = yaw_ab + 16'(i) * step;
      p32 = {pyaw, 16'h0};
      r = base_r;
      pz = cz;
      if (!outpost_mode) begin
        if (i == 1 || i == 3) begin
          r = base_r + longint'(radius_delta_i);
          pz = cz + longint'(height_delta_a_i);
        end
      end else if (i == 0) begin
        pz = cz + longint'(height_delta_a_i);
      end else if (i == 2) begin
        pz = cz + longint'(height_delta_b_i);
      end
      plate_trig(p32, c, s);
      diff = p32 - bearing + 32'h8000;
      p.idx = 2'(i);
      p.x = clamp24(cx - rnd_shift(r * c, 30));
      p.y = clamp24(cy - rnd_shift(r * s, 30));
      p.z = clamp24(pz);
      p.yaw = pyaw;
      p.err = diff[31:16];
      p.last = (i == count - 1);
      plate_q = {plate_q, p};
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    plate_t w;
    if (!rst_ni) begin
      outpost_mode <= 1'b0;
      lead_time <= 16'h0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegLayout) outpost_mode <= cfg_data_i[0];
        else if (cfg_idx_i == RegTime) lead_time <= cfg_data_i;
      end
      if (valid_i && ready_o) predict_plates();
      if (valid_o && ready_i) begin
        if (plate_q.size() == 0) begin
          report("unexpected plate", {30'h0, plate_index_o}, 32'h0);
        end else begin
          w = plate_q.pop_front();
          if (plate_index_o != w.idx) report("plate_index", plate_index_o, w.idx);
          if (plate_x_o != w.x) report("plate_x", plate_x_o, w.x);
          if (plate_y_o != w.y) report("plate_y", plate_y_o, w.y);
          if (plate_z_o != w.z) report("plate_z", plate_z_o, w.z);
          if (plate_yaw_o != w.yaw) report("plate_yaw", plate_yaw_o, w.yaw);
          if (bearing_offset_o != w.err) report("bearing_offset", bearing_offset_o, w.err);
          if (last_plate_o != w.last) report("last_plate", last_plate_o, w.last);
        end
      end
    end
  end

endmodule

>>> tb/tb_armor_plate_position_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_armor_plate_position_predictor
// Drives target requests through several layout and lead-time settings with
// random idling on both sides; the checker predicts and compares every plate.
// ----------------------------------------------------------------------------
module tb_armor_plate_position_predictor;
  import appp_pkg::*;

  localparam int Limit = 300000;

  typedef struct {
    logic signed [23:0] cx, cy, cz, vx, vy, vz;
    logic signed [15:0] hd;
    logic signed [20:0] rate;
    logic [19:0]        rad;
    logic signed [19:0] rd, ha, hb;
  } target_req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [15:0]        cfg_data_i = '0;
  logic               valid_i = 1'b0;
  logic               ready_o;
  logic signed [23:0] center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic signed [23:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic signed [15:0] heading_i = '0;
  logic signed [20:0] heading_rate_i = '0;
  logic [19:0]        plate_radius_i = '0;
  logic signed [19:0] radius_delta_i = '0, height_delta_a_i = '0, height_delta_b_i = '0;
  logic               valid_o;
  logic               ready_i = 1'b0;
  logic [1:0]         plate_index_o;
  logic signed [23:0] plate_x_o, plate_y_o, plate_z_o;
  logic signed [15:0] plate_yaw_o, bearing_offset_o;
  logic               last_plate_o;
  int                 fail_count, plates_pending;
  int                 cycle_count = 0;
  bit                 no_idle = 0;

  always #5 clk_i = ~clk_i;

  armor_plate_position_predictor dut (.*);

  plate_prediction_checker checker_i (.*, .fail_count_o(fail_count),
    .plates_pending_o(plates_pending));

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    ready_i <= no_idle || ($urandom_range(99) >= 27);
    if (cycle_count >= Limit) begin
      $display("armor_plate_position_predictor test failed");
      $finish;
    end
  end

  task automatic send_target(input target_req_t t);
    while (!no_idle && $urandom_range(99) < 27) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    center_x_i <= t.cx; center_y_i <= t.cy; center_z_i <= t.cz;
    vel_x_i <= t.vx; vel_y_i <= t.vy; vel_z_i <= t.vz;
    heading_i <= t.hd; heading_rate_i <= t.rate; plate_radius_i <= t.rad;
    radius_delta_i <= t.rd; height_delta_a_i <= t.ha; height_delta_b_i <= t.hb;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (plates_pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic layout, input logic [15:0] lead);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= RegLayout; cfg_data_i <= {15'h0, layout};
    @(posedge clk_i);
    cfg_idx_i <= RegTime; cfg_data_i <= lead;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic target_req_t rand_target();
    target_req_t t;
    bit          wide;
    wide = ($urandom_range(3) == 0);
    t.cx = wide ? 24'($urandom) : 24'($signed(20'($urandom)));
    t.cy = wide ? 24'($urandom) : 24'($signed(20'($urandom)));
    t.cz = wide ? 24'($urandom) : 24'($signed(20'($urandom)));
    t.vx = wide ? 24'($urandom) : 24'($signed(18'($urandom)));
    t.vy = wide ? 24'($urandom) : 24'($signed(18'($urandom)));
    t.vz = wide ? 24'($urandom) : 24'($signed(18'($urandom)));
    t.hd = 16'($urandom);
    t.rate = 21'($urandom);
    t.rad = wide ? 20'($urandom) : 20'($urandom_range(40000));
    t.rd = wide ? 20'($urandom) : 20'($signed(14'($urandom)));
    t.ha = 20'($urandom);
    t.hb = 20'($urandom);
    return t;
  endfunction

  task automatic directed_set();
    target_req_t t;
    t = '{default: '0};
    t.rad = 20'd16384;
    send_target(t);
    t.hd = 16'sh8000; t.cx = 24'sd65536; send_target(t);
    t.hd = 16'sh7FFF; t.cx = -24'sd65536; t.cy = 24'sd3; send_target(t);
    t = '{cx: 24'sh7FFFFF, cy: 24'sh7FFFFF, cz: 24'sh7FFFFF, vx: 24'sh7FFFFF,
          vy: 24'sh7FFFFF, vz: 24'sh7FFFFF, hd: 16'sh7FFF, rate: 21'sh0FFFFF,
          rad: 20'hFFFFF, rd: 20'sh7FFFF, ha: 20'sh7FFFF, hb: 20'sh7FFFF};
    send_target(t);
    t = '{cx: 24'sh800000, cy: 24'sh800000, cz: 24'sh800000, vx: 24'sh800000,
          vy: 24'sh800000, vz: 24'sh800000, hd: 16'sh8000, rate: 21'sh100000,
          rad: 20'h0, rd: 20'sh80000, ha: 20'sh80000, hb: 20'sh80000};
    send_target(t);
    t = '{cx: 24'sd100000, cy: -24'sd50000, cz: 24'sd1000, vx: -24'sd70000,
          vy: 24'sd30000, vz: 24'sd0, hd: 16'sd8192, rate: 21'sd40000,
          rad: 20'd200, rd: -20'sd100000, ha: -20'sd5000, hb: 20'sd7000};
    send_target(t);
    t.cx = 24'sh800000; t.cy = 24'sh7FFFFF; t.rad = 20'hFFFFF; t.rd = 20'sh7FFFF;
    send_target(t);
    t.cx = 24'sd0; t.cy = -24'sd1; t.hd = 16'sd16384; send_target(t);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    directed_set();
    set_mode(1'b1, 16'hFFFF);
    directed_set();
    set_mode(1'b0, 16'd6554);
    no_idle = 1;
    repeat (60) send_target(rand_target());
    no_idle = 0;
    repeat (50) send_target(rand_target());
    drain();
    repeat (20) send_target(rand_target());
    set_mode(1'b1, 16'd0);
    repeat (70) send_target(rand_target());
    set_mode(1'b0, 16'hFFFF);
    repeat (60) send_target(rand_target());
    set_mode(1'b1, 16'd1000);
    repeat (60) send_target(rand_target());
    set_mode(1'b0, 16'($urandom));
    repeat (50) send_target(rand_target());
    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("armor_plate_position_predictor test passed");
    end else begin
      $display("armor_plate_position_predictor test failed");
    end
    $finish;
  end

endmodule
